// File: rtl/adapter_mismatch_trim_search_top_defines.svh
// assertion macros shared by the checker
`ifndef ADAPTER_MISMATCH_TRIM_SEARCH_TOP_DEFINES_SVH
`define ADAPTER_MISMATCH_TRIM_SEARCH_TOP_DEFINES_SVH

// same-cycle implication, reset masked
`define AMTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("amts assertion failed");

// next-cycle implication, reset masked
`define AMTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("amts assertion failed");

`endif

// File: rtl/amts_pkg.sv
// shared types and constants for the adapter trim search
package amts_pkg;

    localparam int BASE_W      = 8;
    localparam int IDX_W       = 6;
    localparam int ALEN_W      = 7;
    localparam int CUT_W       = 10;
    localparam int KEPT_W      = 9;
    localparam int READ_MAX    = 256;
    localparam int MATCH_REQ   = 4;
    localparam int SPAN_SHIFT  = 3;
    localparam int ALEN_FOUR   = 16;
    localparam int ALEN_THREE  = 12;
    localparam int ALEN_TWO    = 8;
    localparam int START_FOUR  = -4;
    localparam int START_THREE = -3;
    localparam int START_TWO   = -2;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic              valid;
    } amts_tok_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [BASE_W-1:0] data;
    } amts_wr_t;

endpackage

// File: rtl/amts_cell.sv
// one comparison cell: adapter character, two-stage read shift, mismatch accumulate
module amts_cell
    import amts_pkg::*;
#(
    parameter int SW = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              wr_en,
    input  logic [BASE_W-1:0] wr_data,
    input  logic              active,
    input  amts_tok_t         tok_in,
    input  logic [SW-1:0]     sum_in,
    output amts_tok_t         tok_out,
    output logic [SW-1:0]     sum_out
);

    logic [BASE_W-1:0] adp_reg;
    amts_tok_t         r1_reg;
    amts_tok_t         r2_reg;
    logic [SW-1:0]     sum_reg;
    logic              mism;

    assign mism = active && r1_reg.valid && (r1_reg.base != adp_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            adp_reg <= wr_data;
        end
        sum_reg <= sum_in + SW'(mism);
    end

    // read bases move at half the speed of the sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_reg <= '0;
            r2_reg <= '0;
        end
        else if (clear)
        begin
            r1_reg <= '0;
            r2_reg <= '0;
        end
        else
        begin
            r1_reg <= tok_in;
            r2_reg <= r1_reg;
        end
    end

    assign tok_out = r2_reg;
    assign sum_out = sum_reg;

endmodule

// File: rtl/amts_chain.sv
// row of comparison cells, adapter stored in reverse along the row
module amts_chain
    import amts_pkg::*;
#(
    parameter int ADAPTER_MAX = 64,
    parameter int SW          = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  amts_wr_t          wr,
    input  logic [ALEN_W-1:0] alen,
    input  amts_tok_t         feed,
    output logic [SW-1:0]     sum
);

    amts_tok_t     tok_w [ADAPTER_MAX+1];
    logic [SW-1:0] sum_w [ADAPTER_MAX+1];

    assign tok_w[0] = feed;
    assign sum_w[0] = '0;

    genvar k;
    generate
        for (k = 0; k < ADAPTER_MAX; k++)
        begin : g_cell
            // cell k holds adapter character ADAPTER_MAX-1-k
            amts_cell #(.SW(SW)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .clear   (clear),
                .wr_en   (wr.en && (wr.idx == IDX_W'(ADAPTER_MAX - 1 - k))),
                .wr_data (wr.data),
                .active  (alen > ALEN_W'(ADAPTER_MAX - 1 - k)),
                .tok_in  (tok_w[k]),
                .sum_in  (sum_w[k]),
                .tok_out (tok_w[k+1]),
                .sum_out (sum_w[k+1])
            );
        end
    endgenerate

    assign sum = sum_w[ADAPTER_MAX];

endmodule

// File: rtl/adapter_mismatch_trim_search_top.sv
// top level of the adapter trim search: read store, search control, result register
// Adapter writes and non-final read bases are taken while idle. The final base of a read
// starts a search that streams the stored read through a row of ADAPTER_MAX cells, each
// holding one adapter character; one candidate offset leaves the row per cycle, and the
// search ends at the first offset that matches, or with no match once the offset reaches
// read length - 4. With an adapter length under 4 the search goes straight from S_SEARCH
// to S_DONE with no match. No new request is taken during the search; a finished result
// may wait in the output register while new adapter writes and read bases are taken.
module adapter_mismatch_trim_search_top
    import amts_pkg::*;
#(
    parameter int ADAPTER_MAX = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [ALEN_W-1:0]       cfg_wr_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    func,
    input  logic [BASE_W-1:0]       base,
    input  logic [IDX_W-1:0]        adapter_index,
    input  logic                    last,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    found,
    output logic signed [CUT_W-1:0] cut_position,
    output logic [KEPT_W-1:0]       kept_length,
    output logic                    too_long
);

    localparam int AW  = $clog2(READ_MAX);
    localparam int CW  = $clog2(READ_MAX + 1);
    localparam int SW  = $clog2(ADAPTER_MAX + 1);
    localparam int PW0 = $clog2(READ_MAX + 2 * ADAPTER_MAX + 2) + 1;
    localparam int PW  = (PW0 < 8) ? 8 : PW0;
    localparam logic signed [PW-1:0] POS_INIT = PW'(-(2 * ADAPTER_MAX + 1));

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_DONE} state_t;

    state_t                   state_reg, state_next;
    logic [ALEN_W-1:0]        alen_reg, alen_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     ovf_reg, ovf_next;
    logic [CW-1:0]            rlen_reg, rlen_next;
    logic                     tl_reg, tl_next;
    logic [CW-1:0]            ctr_reg, ctr_next;
    logic signed [PW-1:0]     pos_reg, pos_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic [BASE_W-1:0]        rd_data_reg;
    logic                     res_found_reg, res_found_next;
    logic signed [PW-1:0]     res_cut_reg, res_cut_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     found_reg, found_next;
    logic signed [CUT_W-1:0]  cut_reg, cut_next;
    logic [KEPT_W-1:0]        kept_reg, kept_next;
    logic                     too_long_reg, too_long_next;

    logic [BASE_W-1:0]        read_mem [READ_MAX];

    logic                     acc;
    logic                     room;
    logic                     mem_we;
    logic                     start_search;
    logic [ALEN_W-1:0]        alen;
    logic signed [PW-1:0]     start_s;
    logic signed [PW-1:0]     rlen_s;
    logic signed [PW-1:0]     diff;
    logic [ALEN_W-1:0]        cmplen;
    logic [ALEN_W-1:0]        allowed;
    logic [SW-1:0]            sum;
    amts_wr_t                 wr;
    amts_tok_t                feed;

    assign in_ready     = (state_reg == S_IDLE);
    assign acc          = in_valid && in_ready;
    assign room         = (cnt_reg < CW'(READ_MAX));
    assign mem_we       = acc && func && room;
    assign start_search = acc && func && last;

    assign alen = (alen_reg > ALEN_W'(ADAPTER_MAX)) ? ALEN_W'(ADAPTER_MAX) : alen_reg;

    always_comb
    begin
        if (alen >= ALEN_W'(ALEN_FOUR))
        begin
            start_s = PW'(START_FOUR);
        end
        else if (alen >= ALEN_W'(ALEN_THREE))
        begin
            start_s = PW'(START_THREE);
        end
        else if (alen >= ALEN_W'(ALEN_TWO))
        begin
            start_s = PW'(START_TWO);
        end
        else
        begin
            start_s = '0;
        end
    end

    // overlap length and mismatch budget for the offset leaving the row
    assign rlen_s  = signed'({{(PW - CW){1'b0}}, rlen_reg});
    assign diff    = rlen_s - pos_reg;
    assign cmplen  = (diff > signed'({{(PW - ALEN_W){1'b0}}, alen})) ? alen : diff[ALEN_W-1:0];
    assign allowed = cmplen >> SPAN_SHIFT;

    assign wr   = '{en: acc && !func, idx: adapter_index, data: base};
    assign feed = '{base: rd_data_reg, valid: rd_valid_reg};

    amts_chain #(
        .ADAPTER_MAX (ADAPTER_MAX),
        .SW          (SW)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (start_search),
        .wr    (wr),
        .alen  (alen),
        .feed  (feed),
        .sum   (sum)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            read_mem[cnt_reg[AW-1:0]] <= base;
        end
        rd_data_reg <= read_mem[ctr_reg[AW-1:0]];
    end

    always_comb
    begin
        state_next     = state_reg;
        alen_next      = cfg_wr_en ? cfg_wr_data : alen_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        rlen_next      = rlen_reg;
        tl_next        = tl_reg;
        ctr_next       = ctr_reg;
        pos_next       = pos_reg;
        rd_valid_next  = 1'b0;
        res_found_next = res_found_reg;
        res_cut_next   = res_cut_reg;
        out_valid_next = out_valid_reg && !out_ready;
        found_next     = found_reg;
        cut_next       = cut_reg;
        kept_next      = kept_reg;
        too_long_next  = too_long_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (acc && func)
                begin
                    if (room)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        rlen_next  = room ? cnt_reg + CW'(1) : cnt_reg;
                        tl_next    = ovf_reg || !room;
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        ctr_next   = '0;
                        pos_next   = POS_INIT;
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                rd_valid_next = (ctr_reg < rlen_reg);
                if (ctr_reg < rlen_reg)
                begin
                    ctr_next = ctr_reg + CW'(1);
                end
                pos_next = pos_reg + PW'(1);
                if (alen < ALEN_W'(MATCH_REQ))
                begin
                    res_found_next = 1'b0;
                    state_next     = S_DONE;
                end
                else if (pos_reg >= start_s)
                begin
                    if (pos_reg >= rlen_s - PW'(MATCH_REQ))
                    begin
                        res_found_next = 1'b0;
                        state_next     = S_DONE;
                    end
                    else if ({1'b0, sum} <= SW'(allowed) + (SW + 1)'(0))
                    begin
                        res_found_next = 1'b1;
                        res_cut_next   = pos_reg;
                        state_next     = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = res_found_reg;
                    too_long_next  = tl_reg;
                    if (res_found_reg)
                    begin
                        cut_next  = CUT_W'(res_cut_reg);
                        kept_next = res_cut_reg[PW-1] ? '0 : KEPT_W'(res_cut_reg);
                    end
                    else
                    begin
                        cut_next  = '0;
                        kept_next = KEPT_W'(rlen_reg);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            alen_reg      <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            rlen_reg      <= '0;
            tl_reg        <= 1'b0;
            ctr_reg       <= '0;
            pos_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            res_found_reg <= 1'b0;
            res_cut_reg   <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            cut_reg       <= '0;
            kept_reg      <= '0;
            too_long_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alen_reg      <= alen_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            rlen_reg      <= rlen_next;
            tl_reg        <= tl_next;
            ctr_reg       <= ctr_next;
            pos_reg       <= pos_next;
            rd_valid_reg  <= rd_valid_next;
            res_found_reg <= res_found_next;
            res_cut_reg   <= res_cut_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            cut_reg       <= cut_next;
            kept_reg      <= kept_next;
            too_long_reg  <= too_long_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign cut_position = cut_reg;
    assign kept_length  = kept_reg;
    assign too_long     = too_long_reg;

endmodule

// File: rtl/amts_checker.sv
// port-level checks on the adapter trim search results, bound to the top level
`include "adapter_mismatch_trim_search_top_defines.svh"

module amts_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic              found,
    input logic signed [9:0] cut_position,
    input logic [8:0]        kept_length,
    input logic              too_long
);

    `AMTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(found) && $stable(cut_position) && $stable(kept_length) && $stable(too_long))
    `AMTS_ASSERT_NOW(a_miss_cut_zero, out_valid && !found, cut_position == 10'sd0)
    `AMTS_ASSERT_NOW(a_neg_cut_keeps_none, out_valid && found && cut_position[9], kept_length == 9'd0)
    `AMTS_ASSERT_NOW(a_pos_cut_kept, out_valid && found && !cut_position[9], kept_length == cut_position[8:0])

endmodule

bind adapter_mismatch_trim_search_top amts_checker u_amts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .cut_position (cut_position),
    .kept_length  (kept_length),
    .too_long     (too_long)
);
